FILE: rtl/der_pkg.sv
// ----------------------------------------------------------------------------
// der_pkg
// Shared types and constants of the dual ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package der_pkg;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_TRIG = 2'd1,
    FN_STOP = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ES_NEXT_OK = 4'b0001,
    ES_OK      = 4'b0010,
    ES_LOST    = 4'b0100,
    ES_LONG    = 4'b1000
  } echo_st_t;

  localparam logic [1:0] CODE_NEXT_OK = 2'd0;
  localparam logic [1:0] CODE_OK      = 2'd1;
  localparam logic [1:0] CODE_LOST    = 2'd2;
  localparam logic [1:0] CODE_LONG    = 2'd3;

  localparam logic [15:0] DIST_MAX_RST = 16'd1000;
  localparam logic [15:0] SEP_RST      = 16'd16;

  localparam logic [2:0] ADDR_DIST_MAX = 3'd0;
  localparam logic [2:0] ADDR_SEP      = 3'd4;

  // A fused value at or above this cap always saturates after smoothing.
  localparam int unsigned FUSE_CAP = 81920;
  // Reciprocal of five scaled by 2^22, rounded up.
  localparam logic [19:0] RECIP5 = 20'd838861;
  localparam int unsigned RECIP_SHIFT = 22;

  typedef struct packed {
    echo_st_t status;
    logic     trig;
  } sns_view_t;

  function automatic logic [1:0] status_code(echo_st_t st);
    logic [1:0] code;
    unique case (st)
      ES_NEXT_OK: code = CODE_NEXT_OK;
      ES_OK:      code = CODE_OK;
      ES_LOST:    code = CODE_LOST;
      ES_LONG:    code = CODE_LONG;
      default:    code = CODE_NEXT_OK;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/der_sensor.sv
// ----------------------------------------------------------------------------
// der_sensor
// One sensor channel: echo pulse timing, window check and trigger re-arm.
// ----------------------------------------------------------------------------
module der_sensor import der_pkg::*; #(
  parameter int CW = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  func_t         func,
  input  logic          echo,
  input  logic [15:0]   dist_max,
  output sns_view_t     view,
  output logic [DW-1:0] echo_dist_next
);

  logic          armed, armed_next;
  logic          timing, timing_next;
  logic [CW-1:0] count, count_next;
  logic [DW-1:0] echo_dist;
  echo_st_t      status, status_next;
  logic          trig, trig_next;
  logic          armed_chk;
  logic [DW-1:0] dmax;

  assign dmax = DW'(dist_max);

  always_comb begin
    armed_next     = armed;
    timing_next    = timing;
    count_next     = count;
    echo_dist_next = echo_dist;
    status_next    = status;
    trig_next      = trig;
    armed_chk      = (status == ES_LONG) ? 1'b0 : armed;
    unique case (func)
      FN_TICK: begin
        if (timing) begin
          if (!(&count)) begin
            count_next = count + 1'b1;
          end
          if (!echo) begin
            timing_next = 1'b0;
            if (status == ES_OK || status == ES_NEXT_OK) begin
              echo_dist_next = DW'(count_next);
            end
          end
        end else if (armed && echo) begin
          count_next  = '0;
          timing_next = 1'b1;
          armed_next  = 1'b0;
        end
      end
      FN_TRIG: begin
        if (timing) begin
          status_next    = ES_LONG;
          echo_dist_next = dmax;
        end else if (armed_chk) begin
          status_next    = ES_LOST;
          echo_dist_next = dmax;
        end else if (status == ES_LONG) begin
          status_next    = ES_NEXT_OK;
          echo_dist_next = dmax;
        end else begin
          status_next = ES_OK;
        end
        if (status_next != ES_LONG) begin
          trig_next  = 1'b1;
          armed_next = 1'b1;
        end else begin
          armed_next = 1'b0;
        end
      end
      FN_STOP: begin
        trig_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      timing    <= 1'b0;
      count     <= '0;
      echo_dist <= DW'(DIST_MAX_RST);
      status    <= ES_NEXT_OK;
      trig      <= 1'b0;
    end else if (step) begin
      armed     <= armed_next;
      timing    <= timing_next;
      count     <= count_next;
      echo_dist <= echo_dist_next;
      status    <= status_next;
      trig      <= trig_next;
    end
  end

  assign view.status = status_next;
  assign view.trig   = trig_next;

endmodule

FILE: rtl/der_fuse.sv
// ----------------------------------------------------------------------------
// der_fuse
// Fuses the two sensor distances and keeps the smoothed distance.
// ----------------------------------------------------------------------------
module der_fuse import der_pkg::*; #(
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          do_trig,
  input  logic [15:0]   dist_max,
  input  logic [15:0]   sep_threshold,
  input  logic          left_ok,
  input  logic          right_ok,
  input  logic [DW-1:0] left_dist,
  input  logic [DW-1:0] right_dist,
  output logic [15:0]   smoothed_next
);

  localparam int FW = (DW > 17) ? DW : 17;

  logic [15:0]   smoothed;
  logic [DW-1:0] dmax;
  logic [DW-1:0] sep;
  logic [DW-1:0] diff;
  logic [DW-1:0] lo;
  logic [DW:0]   pair_sum;
  logic [DW-1:0] fused;
  logic [FW-1:0] fused_wide;
  logic [16:0]   fused_cap;
  logic [18:0]   blend;
  logic [38:0]   prod;
  logic [16:0]   quot;

  assign dmax     = DW'(dist_max);
  assign sep      = DW'(sep_threshold);
  assign diff     = (left_dist > right_dist) ? (left_dist - right_dist)
                                             : (right_dist - left_dist);
  assign lo       = (left_dist < right_dist) ? left_dist : right_dist;
  assign pair_sum = {1'b0, left_dist} + {1'b0, right_dist};

  always_comb begin
    if (!left_ok) begin
      fused = (right_dist > dmax) ? dmax : right_dist;
    end else if (!right_ok) begin
      fused = (left_dist > dmax) ? dmax : left_dist;
    end else if (left_dist >= dmax && right_dist >= dmax) begin
      fused = dmax;
    end else if (diff > sep) begin
      fused = lo;
    end else begin
      fused = pair_sum[DW:1];
    end
  end

  assign fused_wide = FW'(fused);
  assign fused_cap  = (fused_wide > FW'(FUSE_CAP)) ? 17'(FUSE_CAP) : fused_wide[16:0];
  assign blend      = {fused_cap, 2'b00} + 19'(smoothed);
  assign prod       = 39'(blend) * 39'(RECIP5);
  assign quot       = prod[RECIP_SHIFT+16:RECIP_SHIFT];

  always_comb begin
    if (do_trig) begin
      smoothed_next = quot[16] ? 16'hFFFF : quot[15:0];
    end else begin
      smoothed_next = smoothed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= DIST_MAX_RST;
    end else if (step) begin
      smoothed <= smoothed_next;
    end
  end

endmodule

FILE: rtl/dual_ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_echo_ranger
// Times the echo pulses of two ultrasonic sensors, fuses and smooths the
// two distances, and drives both trigger pins.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  item      item_valid / item_ready     func, echo_left, echo_right
//  result    result_valid / result_ready trig_left, trig_right, distance,
//                                        left_status, right_status
//  config    psel / penable / pready     pwrite, paddr, pwdata, prdata
//
// Each beat is captured in an input register, and its result is registered
// in the output register once that is free or read. One beat is taken every
// cycle while results are accepted. The state update and the divide-by-five
// multiply share a single stage. A stalled result holds the output register
// and the pending input register; input is refused only when both are full.
// Synchronous reset clears all state except the held beat and output data.
// ----------------------------------------------------------------------------
module dual_ultrasonic_echo_ranger import der_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  func,
  input  logic        echo_left,
  input  logic        echo_right,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        trig_left,
  output logic        trig_right,
  output logic [15:0] distance,
  output logic [1:0]  left_status,
  output logic [1:0]  right_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic          hold_valid;
  func_t         hold_func;
  logic          hold_el;
  logic          hold_er;
  logic          step;
  logic [15:0]   dist_max;
  logic [15:0]   sep_threshold;
  sns_view_t     left_view;
  sns_view_t     right_view;
  logic [DW-1:0] left_dist;
  logic [DW-1:0] right_dist;
  logic [15:0]   smoothed_next;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_max      <= DIST_MAX_RST;
      sep_threshold <= SEP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ADDR_DIST_MAX[2]: dist_max      <= pwdata[15:0];
        ADDR_SEP[2]:      sep_threshold <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_DIST_MAX[2]: prdata = 32'(dist_max);
      ADDR_SEP[2]:      prdata = 32'(sep_threshold);
      default:          prdata = '0;
    endcase
  end

  assign step       = hold_valid && (!result_valid || result_ready);
  assign item_ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold_func <= func_t'(func);
      hold_el   <= echo_left;
      hold_er   <= echo_right;
    end
  end

  der_sensor #(.CW(COUNT_WIDTH), .DW(DW)) u_left (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .func          (hold_func),
    .echo          (hold_el),
    .dist_max      (dist_max),
    .view          (left_view),
    .echo_dist_next(left_dist)
  );

  der_sensor #(.CW(COUNT_WIDTH), .DW(DW)) u_right (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .func          (hold_func),
    .echo          (hold_er),
    .dist_max      (dist_max),
    .view          (right_view),
    .echo_dist_next(right_dist)
  );

  der_fuse #(.DW(DW)) u_fuse (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .do_trig      (hold_func == FN_TRIG),
    .dist_max     (dist_max),
    .sep_threshold(sep_threshold),
    .left_ok      (left_view.status == ES_OK),
    .right_ok     (right_view.status == ES_OK),
    .left_dist    (left_dist),
    .right_dist   (right_dist),
    .smoothed_next(smoothed_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      trig_left    <= left_view.trig;
      trig_right   <= right_view.trig;
      distance     <= smoothed_next;
      left_status  <= status_code(left_view.status);
      right_status <= status_code(right_view.status);
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item_ready low while the output register is empty");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("processed beat did not produce a result");

  a_stop_drops_trig: assert property (@(posedge clk) disable iff (rst)
    step && hold_func == FN_STOP |=> !trig_left && !trig_right)
    else $error("trigger pins still high after a stop beat");

  a_distance_kept: assert property (@(posedge clk) disable iff (rst)
    step && result_valid && hold_func != FN_TRIG |=> distance == $past(distance))
    else $error("distance changed on a beat that is not a trigger");

endmodule
